[hdl/mts_pkg.sv]
// shared types and constants for the multi-timer scheduler
package mts_pkg;

  localparam int NUM_TIMERS_DEF = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] MODE_CYCLIC  = 2'd0;
  localparam logic [1:0] MODE_LIMITED = 2'd1;

  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_REMOVED  = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND = 3'd3;
  localparam logic [2:0] KIND_FIRED    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] user_id;
    logic [30:0] interval_ms;
    logic [1:0]  mode;
    logic [30:0] repeat_count;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_id;
    logic        finished;
    logic        last;
  } out_res_t;

  // request token walking the cell row, carrying one held-back result
  typedef struct packed {
    logic        active;
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [30:0] period;
    logic [1:0]  mode;
    logic [30:0] count;
    logic [63:0] deadline;
    logic        done;
    logic        held_valid;
    logic [2:0]  held_kind;
    logic [31:0] held_id;
    logic        held_fin;
  } probe_t;

  typedef struct packed {
    logic     valid;
    out_res_t res;
  } emit_t;

endpackage

[hdl/multi_timer_scheduler_core.sv]
// top level of the multi-timer scheduler: cell row, time base and result port
// Table of NUM_TIMERS software timers on a millisecond tick. A request (add,
// remove or tick) is taken when start is high and busy is low; it then walks
// the row of timer cells, one cell per cycle, and busy stays high until
// the request has left the row, so a new request cannot be taken before
// the current one has passed every cell. Results come out on out_res with
// out_valid high for exactly one cycle each, in slot order, at most one per
// cycle; the receiver cannot stall them, and out_res.last marks the final
// result of a request, which is shown in the cycle busy is already low. Add
// and remove give one result each, a tick gives one per timer that fires, and
// a quiet tick or an unused command gives none.
module multi_timer_scheduler_core
  import mts_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  logic [63:0] now_r, now_nxt;
  logic        busy_r, busy_nxt;
  probe_t      entry_r, entry_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_res_r, out_res_nxt;

  probe_t                  probe_w [NUM_TIMERS+1];
  emit_t                   emit_w  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]   emit_vec;
  probe_t                  tail;
  logic                    accept;
  logic [30:0]             period_eff;

  assign accept     = start && !busy_r;
  // zero interval counts as one millisecond
  assign period_eff = (in_req.interval_ms == 31'd0) ? 31'd1 : in_req.interval_ms;

  // time base and request launch
  always_comb begin
    now_nxt   = now_r;
    entry_nxt = '0;
    if (accept) begin
      if (in_req.cmd == CMD_TICK) begin
        now_nxt = now_r + 64'd1;
      end
      entry_nxt.active   = 1'b1;
      entry_nxt.cmd      = in_req.cmd;
      entry_nxt.id       = in_req.user_id;
      entry_nxt.period   = period_eff;
      entry_nxt.mode     = in_req.mode;
      entry_nxt.count    = in_req.repeat_count;
      entry_nxt.deadline = now_r + {33'd0, period_eff};
    end
  end

  // the row of timer cells
  assign probe_w[0] = entry_r;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    mts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .now_ms  (now_r),
      .probe_i (probe_w[g]),
      .probe_o (probe_w[g+1]),
      .emit_o  (emit_w[g])
    );
    assign emit_vec[g] = emit_w[g].valid;
  end

  assign tail = probe_w[NUM_TIMERS];

  // result collection: only one cell holds the request, so an or-merge suffices
  always_comb begin
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    busy_nxt      = busy_r;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (emit_w[i].valid) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = out_res_nxt | emit_w[i].res;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tail.active) begin
      // request leaves the row: flush the held result, or report a miss
      busy_nxt = 1'b0;
      out_res_nxt.last = 1'b1;
      if (tail.held_valid) begin
        out_valid_nxt         = 1'b1;
        out_res_nxt.kind      = tail.held_kind;
        out_res_nxt.result_id = tail.held_id;
        out_res_nxt.finished  = tail.held_fin;
      end else if (tail.cmd == CMD_ADD) begin
        out_valid_nxt         = 1'b1;
        out_res_nxt.kind      = KIND_FULL;
        out_res_nxt.result_id = tail.id;
        out_res_nxt.finished  = 1'b0;
      end else if (tail.cmd == CMD_REMOVE) begin
        out_valid_nxt         = 1'b1;
        out_res_nxt.kind      = KIND_NOTFOUND;
        out_res_nxt.result_id = tail.id;
        out_res_nxt.finished  = 1'b0;
      end else begin
        out_valid_nxt    = 1'b0;
        out_res_nxt.last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      busy_r      <= 1'b0;
      entry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      busy_r      <= busy_nxt;
      entry_r     <= entry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a result only follows a request in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result without a request in flight");

  // never two cells pushing out a result in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(emit_vec))
    else $error("more than one cell emitting");

  // an accepted request raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after accept");

  // the final result of a request comes with busy already low
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.last) |-> !busy_r)
    else $error("last result while still busy");

endmodule

[hdl/mts_cell.sv]
// one timer slot of the scheduler row
module mts_cell
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] now_ms,
  input  probe_t      probe_i,
  output probe_t      probe_o,
  output emit_t       emit_o
);

  logic        valid_r, valid_nxt;
  logic [31:0] id_r, id_nxt;
  logic [63:0] deadline_r, deadline_nxt;
  logic [30:0] period_r, period_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [30:0] remaining_r, remaining_nxt;
  probe_t      probe_r, probe_nxt;

  logic        hit_add, hit_rem, hit_fire, rearm, new_valid;
  logic [2:0]  new_kind;
  logic [31:0] new_id;
  logic        new_fin;

  always_comb begin
    hit_add  = probe_i.active && (probe_i.cmd == CMD_ADD) && !probe_i.done && !valid_r;
    hit_rem  = probe_i.active && (probe_i.cmd == CMD_REMOVE) && !probe_i.done &&
               valid_r && (id_r == probe_i.id);
    hit_fire = probe_i.active && (probe_i.cmd == CMD_TICK) && valid_r &&
               (deadline_r == now_ms);
    rearm    = (mode_r == MODE_CYCLIC) ||
               ((mode_r == MODE_LIMITED) && (remaining_r > 31'd1));

    valid_nxt     = valid_r;
    id_nxt        = id_r;
    deadline_nxt  = deadline_r;
    period_nxt    = period_r;
    mode_nxt      = mode_r;
    remaining_nxt = remaining_r;

    new_valid = hit_add || hit_rem || hit_fire;
    new_kind  = KIND_ADDED;
    new_id    = probe_i.id;
    new_fin   = 1'b0;

    if (hit_add) begin
      valid_nxt     = 1'b1;
      id_nxt        = probe_i.id;
      deadline_nxt  = probe_i.deadline;
      period_nxt    = probe_i.period;
      mode_nxt      = probe_i.mode;
      remaining_nxt = probe_i.count;
    end else if (hit_rem) begin
      valid_nxt = 1'b0;
      new_kind  = KIND_REMOVED;
    end else if (hit_fire) begin
      new_kind = KIND_FIRED;
      new_id   = id_r;
      new_fin  = !rearm;
      if (rearm) begin
        deadline_nxt = deadline_r + {33'd0, period_r};
        if (mode_r == MODE_LIMITED) begin
          remaining_nxt = remaining_r - 31'd1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end

    // a newer result pushes the held one out, which then cannot be the last
    emit_o.valid           = new_valid && probe_i.held_valid;
    emit_o.res.kind        = probe_i.held_kind;
    emit_o.res.result_id   = probe_i.held_id;
    emit_o.res.finished    = probe_i.held_fin;
    emit_o.res.last        = 1'b0;

    probe_nxt      = probe_i;
    probe_nxt.done = probe_i.done || hit_add || hit_rem;
    if (new_valid) begin
      probe_nxt.held_valid = 1'b1;
      probe_nxt.held_kind  = new_kind;
      probe_nxt.held_id    = new_id;
      probe_nxt.held_fin   = new_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    deadline_r  <= deadline_nxt;
    period_r    <= period_nxt;
    mode_r      <= mode_nxt;
    remaining_r <= remaining_nxt;
  end

  assign probe_o = probe_r;

endmodule
